### rtl/rtki_pkg.sv
// Shared types and constants of the ranked top-K insertion table.
package rtki_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int RANK_W      = 8;
	localparam int TAG_W       = 16;
	localparam int INDEX_W     = 4;
	localparam int COUNT_W     = 5;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SHIFT,
		ST_PLACE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [RANK_W-1:0]    item_rank;
		logic [TAG_W-1:0]     item_tag;
		logic [INDEX_W-1:0]   read_index;
	} req_t;

	typedef struct packed {
		logic                 accepted;
		logic [INDEX_W-1:0]   placed_at;
		logic [COUNT_W-1:0]   entry_count;
		logic                 read_valid;
		logic [RANK_W-1:0]    read_rank;
		logic [TAG_W-1:0]     read_tag;
	} rsp_t;

endpackage

### rtl/ranked_top_k_insertion_table_top.sv
// Top level of the ranked top-K insertion table: sequencer, table memory and result register.
// The table holds up to TABLE_DEPTH entries sorted by falling rank in a memory with one read
// port and one write port, and one rank comparator walks an insert upward from the bottom of
// the table, moving one entry down per cycle. A clear or a read goes from the idle state
// straight to the finish state; a dropped insert into a full table passes through the check
// state first. An insert into a table that is not full passes through one shift state for
// every entry it pushes down, writes the item in a shift or place state and then finishes; an
// insert into a full table first passes through the check state for the compare with the last
// entry. The finish state waits while the output register holds a result not yet taken.
// The block takes a new item once the previous result sits in the output register, even if
// that result has not yet been taken; it is not ready while an item is being worked on.
module ranked_top_k_insertion_table_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  rtki_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rtki_pkg::rsp_t  rsp
);

	localparam int TABLE_DEPTH = rtki_pkg::TABLE_DEPTH;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > rtki_pkg::INDEX_W) ? CNT_W : rtki_pkg::INDEX_W;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

	// Table memory.
	logic [rtki_pkg::RANK_W-1:0] rank_mem [TABLE_DEPTH];
	logic [rtki_pkg::TAG_W-1:0]  tag_mem  [TABLE_DEPTH];

	rtki_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]            count_q;
	logic [IDX_W-1:0]            pos_q;
	logic [rtki_pkg::RANK_W-1:0] rank_q;
	logic [rtki_pkg::TAG_W-1:0]  tag_q;
	logic                        acc_q;
	logic                        rdv_q;
	logic [rtki_pkg::RANK_W-1:0] rd_rank_q;
	logic [rtki_pkg::TAG_W-1:0]  rd_tag_q;
	logic                        rsp_valid_q;
	rtki_pkg::rsp_t              rsp_q;

	logic                        accept;
	logic                        full;
	logic                        idx_ok;
	logic                        greater;
	logic                        rd_en;
	logic [IDX_W-1:0]            rd_addr;
	logic                        wr_en;
	logic                        wr_item;
	logic [IDX_W-1:0]            wr_addr;
	logic [rtki_pkg::RANK_W-1:0] wr_rank;
	logic [rtki_pkg::TAG_W-1:0]  wr_tag;
	logic                        rsp_load;

	assign accept  = req_valid & req_ready;
	assign full    = (count_q == FULL_COUNT);
	assign idx_ok  = (CMP_W'(req.read_index) < CMP_W'(count_q));
	// The one shared rank comparator: the new rank against the entry just read.
	assign greater = (rank_q > rd_rank_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rtki_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.cmd == rtki_pkg::CMD_INSERT) begin
						if (full) begin
							state_d = rtki_pkg::ST_CHECK;
						end else if (count_q == '0) begin
							state_d = rtki_pkg::ST_PLACE;
						end else begin
							state_d = rtki_pkg::ST_SHIFT;
						end
					end else begin
						state_d = rtki_pkg::ST_FINISH;
					end
				end
			end
			rtki_pkg::ST_CHECK: begin
				state_d = greater ? rtki_pkg::ST_SHIFT : rtki_pkg::ST_FINISH;
			end
			rtki_pkg::ST_SHIFT: begin
				if (!greater) begin
					state_d = rtki_pkg::ST_FINISH;
				end else if (pos_q == IDX_W'(1)) begin
					state_d = rtki_pkg::ST_PLACE;
				end
			end
			rtki_pkg::ST_PLACE: begin
				state_d = rtki_pkg::ST_FINISH;
			end
			rtki_pkg::ST_FINISH: begin
				if (rsp_load) begin
					state_d = rtki_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rtki_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: memory ports and handshake.
	always_comb begin
		req_ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = pos_q - IDX_W'(1);
		wr_en     = 1'b0;
		wr_item   = 1'b0;
		wr_addr   = pos_q;
		wr_rank   = rank_q;
		wr_tag    = tag_q;
		rsp_load  = 1'b0;
		unique case (state_q)
			rtki_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (accept) begin
					if (req.cmd == rtki_pkg::CMD_INSERT) begin
						rd_en   = (count_q != '0);
						rd_addr = full ? LAST_SLOT : IDX_W'(count_q - CNT_W'(1));
					end else if (req.cmd == rtki_pkg::CMD_READ) begin
						rd_en   = idx_ok;
						rd_addr = IDX_W'(req.read_index);
					end
				end
			end
			rtki_pkg::ST_CHECK: begin
				rd_en = greater;
			end
			rtki_pkg::ST_SHIFT: begin
				wr_en = 1'b1;
				if (greater) begin
					// Move the entry above down one slot and look one slot higher.
					wr_rank = rd_rank_q;
					wr_tag  = rd_tag_q;
					rd_en   = (pos_q != IDX_W'(1));
					rd_addr = pos_q - IDX_W'(2);
				end else begin
					wr_item = 1'b1;
				end
			end
			rtki_pkg::ST_PLACE: begin
				wr_en   = 1'b1;
				wr_item = 1'b1;
			end
			rtki_pkg::ST_FINISH: begin
				rsp_load = !rsp_valid_q || rsp_ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rank_mem[wr_addr] <= wr_rank;
			tag_mem[wr_addr]  <= wr_tag;
		end
		if (rd_en) begin
			rd_rank_q <= rank_mem[rd_addr];
			rd_tag_q  <= tag_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rtki_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (req.cmd == rtki_pkg::CMD_CLEAR) begin
					count_q <= '0;
				end else if (req.cmd == rtki_pkg::CMD_INSERT && !full) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rank_q <= req.item_rank;
			tag_q  <= req.item_tag;
			acc_q  <= 1'b0;
			rdv_q  <= (req.cmd == rtki_pkg::CMD_READ) && idx_ok;
			pos_q  <= full ? LAST_SLOT : IDX_W'(count_q);
		end
		if (state_q == rtki_pkg::ST_SHIFT && greater) begin
			pos_q <= pos_q - IDX_W'(1);
		end
		if (wr_item) begin
			acc_q <= 1'b1;
		end
		if (rsp_load) begin
			rsp_q.accepted    <= acc_q;
			rsp_q.placed_at   <= acc_q ? rtki_pkg::INDEX_W'(pos_q) : '0;
			rsp_q.entry_count <= rtki_pkg::COUNT_W'(count_q);
			rsp_q.read_valid  <= rdv_q;
			rsp_q.read_rank   <= rdv_q ? rd_rank_q : '0;
			rsp_q.read_tag    <= rdv_q ? rd_tag_q : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### sim/ranked_top_k_insertion_table_top_tb.sv
// Self-checking testbench for the ranked top-K insertion table with directed and random items.
`timescale 1ns / 100ps

module ranked_top_k_insertion_table_top_tb;

	localparam int DEPTH         = rtki_pkg::TABLE_DEPTH;
	localparam int RANK_W        = rtki_pkg::RANK_W;
	localparam int TAG_W         = rtki_pkg::TAG_W;
	localparam int INDEX_W       = rtki_pkg::INDEX_W;
	localparam int COUNT_W       = rtki_pkg::COUNT_W;
	localparam int RANDOM_ITEMS  = 1700;
	localparam int LONG_HOLD     = 80;
	localparam int CALM_TAIL     = 200;
	localparam int LIMIT_CYCLES  = 400000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		rtki_pkg::req_t payload;
		bit             drain_first;
	} pending_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	rtki_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rtki_pkg::rsp_t rsp;

	pending_item_t pending_items[$];
	rtki_pkg::rsp_t awaited_results[$];

	// Predicted table contents, kept in falling rank order.
	logic [RANK_W-1:0] table_rank [DEPTH];
	logic [TAG_W-1:0]  table_tag  [DEPTH];
	int table_fill = 0;

	int  accepted_count = 0;
	int  fault_count = 0;
	bit  req_taken = 1'b0;
	int  send_gap = 0;
	int  ready_hold = 0;
	bit  first_hold_done = 1'b0;
	bit  second_hold_done = 1'b0;

	ranked_top_k_insertion_table_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	function automatic rtki_pkg::rsp_t apply_command(rtki_pkg::req_t r);
		rtki_pkg::rsp_t o;
		int slot;
		o = '0;
		case (r.cmd)
			rtki_pkg::CMD_CLEAR: begin
				table_fill = 0;
			end
			rtki_pkg::CMD_INSERT: begin
				if (table_fill < DEPTH || r.item_rank > table_rank[DEPTH-1]) begin
					if (table_fill < DEPTH) begin
						slot = table_fill;
						table_fill++;
					end else begin
						slot = DEPTH - 1;
					end
					// Entries of lower rank move down; equal ranks stay above the newcomer.
					while (slot > 0 && r.item_rank > table_rank[slot-1]) begin
						table_rank[slot] = table_rank[slot-1];
						table_tag[slot]  = table_tag[slot-1];
						slot--;
					end
					table_rank[slot] = r.item_rank;
					table_tag[slot]  = r.item_tag;
					o.accepted  = 1'b1;
					o.placed_at = INDEX_W'(slot);
				end
			end
			rtki_pkg::CMD_READ: begin
				if (int'(r.read_index) < table_fill) begin
					o.read_valid = 1'b1;
					o.read_rank  = table_rank[r.read_index];
					o.read_tag   = table_tag[r.read_index];
				end
			end
			default: ;
		endcase
		o.entry_count = COUNT_W'(table_fill);
		return o;
	endfunction

	// No idling near the end of the run, and none in every third stretch of 128 items.
	function automatic bit idle_allowed();
		return pending_items.size() >= CALM_TAIL && ((accepted_count / 128) % 3) != 2;
	endfunction

	task automatic queue_command(input logic [1:0] code, input logic [RANK_W-1:0] rank,
			input logic [TAG_W-1:0] tag, input logic [INDEX_W-1:0] slot, input bit drain);
		pending_item_t p;
		p.payload.cmd        = rtki_pkg::cmd_t'(code);
		p.payload.item_rank  = rank;
		p.payload.item_tag   = tag;
		p.payload.read_index = slot;
		p.drain_first        = drain;
		pending_items.push_back(p);
	endtask

	// Result check first, then prediction for an item taken at the same edge.
	always @(posedge clk) begin
		rtki_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_results.size() == 0) begin
					if (fault_count < 10)
						$display("%0t: result with nothing awaited: %p", $realtime, rsp);
					fault_count++;
				end else begin
					want = awaited_results.pop_front();
					if (rsp.accepted !== want.accepted || rsp.placed_at !== want.placed_at ||
							rsp.entry_count !== want.entry_count ||
							rsp.read_valid !== want.read_valid ||
							rsp.read_rank !== want.read_rank || rsp.read_tag !== want.read_tag) begin
						if (fault_count < 10)
							$display("%0t: mismatch, expected %p, got %p", $realtime, want, rsp);
						fault_count++;
					end
				end
			end
			if (req_valid && req_ready) begin
				awaited_results.push_back(apply_command(req));
				accepted_count++;
			end
		end
		req_taken <= req_valid && req_ready;
	end

	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (send_gap > 0) begin
				req_valid <= 1'b0;
				send_gap  <= send_gap - 1;
			end else if (pending_items.size() == 0) begin
				req_valid <= 1'b0;
			end else if (pending_items[0].drain_first && awaited_results.size() != 0) begin
				req_valid <= 1'b0;
			end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
				req_valid <= 1'b0;
				send_gap  <= $urandom_range(0, 2);
			end else begin
				req       <= pending_items[0].payload;
				req_valid <= 1'b1;
				void'(pending_items.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (ready_hold > 0) begin
			rsp_ready  <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else if (!first_hold_done && accepted_count >= 300) begin
			first_hold_done <= 1'b1;
			rsp_ready       <= 1'b0;
			ready_hold      <= LONG_HOLD - 1;
		end else if (!second_hold_done && accepted_count >= 1000) begin
			second_hold_done <= 1'b1;
			rsp_ready        <= 1'b0;
			ready_hold       <= LONG_HOLD - 1;
		end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
			rsp_ready  <= 1'b0;
			ready_hold <= $urandom_range(0, 2);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	initial begin
		int n;
		int k;
		int len;
		int mode;
		int pick;
		logic [1:0] code;
		logic [RANK_W-1:0] rank;

		// Empty table, unused command, extremes, a tie, then fill to the top.
		queue_command(rtki_pkg::CMD_READ, 8'd0, 16'd0, 4'd0, 1'b0);
		queue_command(CMD_UNUSED, 8'hFF, 16'hFFFF, 4'd15, 1'b0);
		queue_command(rtki_pkg::CMD_INSERT, 8'd0, 16'h0000, 4'd0, 1'b0);
		queue_command(rtki_pkg::CMD_INSERT, 8'hFF, 16'hFFFF, 4'd0, 1'b0);
		queue_command(rtki_pkg::CMD_INSERT, 8'hFF, 16'h1234, 4'd0, 1'b0);
		queue_command(rtki_pkg::CMD_READ, 8'd0, 16'd0, 4'd1, 1'b0);
		for (k = 0; k < 13; k++)
			queue_command(rtki_pkg::CMD_INSERT, RANK_W'(k * 19 + 3), TAG_W'(k + 16'hA500),
				4'd0, 1'b0);
		// Full table: equal rank is dropped, one step higher displaces the last entry.
		queue_command(rtki_pkg::CMD_INSERT, 8'd0, 16'hBEEF, 4'd0, 1'b0);
		queue_command(rtki_pkg::CMD_INSERT, 8'd1, 16'h5A5A, 4'd0, 1'b0);
		queue_command(rtki_pkg::CMD_READ, 8'd0, 16'd0, 4'd15, 1'b0);
		queue_command(rtki_pkg::CMD_CLEAR, 8'hFF, 16'hFFFF, 4'd15, 1'b0);
		queue_command(rtki_pkg::CMD_READ, 8'd0, 16'd0, 4'd0, 1'b0);

		n = 0;
		while (n < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(20, 80);
			if ($urandom_range(0, 2) == 0) begin
				queue_command(rtki_pkg::CMD_CLEAR, RANK_W'($urandom_range(0, 255)),
					TAG_W'($urandom_range(0, 65535)), INDEX_W'($urandom_range(0, 15)),
					n == 600 || n == 1300);
				n++;
			end
			for (k = 0; k < len; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					code = rtki_pkg::CMD_INSERT;
				else if (pick < 93)
					code = rtki_pkg::CMD_READ;
				else if (pick < 96)
					code = rtki_pkg::CMD_CLEAR;
				else
					code = CMD_UNUSED;
				case (mode)
					1: rank = RANK_W'($urandom_range(0, 3));
					2: rank = RANK_W'($urandom_range(250, 255));
					default: rank = RANK_W'($urandom_range(0, 255));
				endcase
				queue_command(code, rank, TAG_W'($urandom_range(0, 65535)),
					INDEX_W'($urandom_range(0, 15)), n == 600 || n == 1300);
				n++;
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_items.size() == 0 && !req_valid && awaited_results.size() == 0);
		repeat (DEPTH + 8) @(posedge clk);
		if (fault_count == 0 && awaited_results.size() == 0)
			$display("ranked_top_k_insertion_table_top_tb: clean");
		else
			$display("ranked_top_k_insertion_table_top_tb: errors");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 12);
		$display("ranked_top_k_insertion_table_top_tb: errors");
		$finish;
	end

endmodule
